### rtl/rld_pkg.sv
// Shared types, constants and helpers for the rectangle/line draw engine.
// No dependencies; rld_queue, rld_front, rld_back, the top level and the bench import it.
package rld_pkg;

	localparam int COORD_W = 12;   // holds any coordinate below 4096
	localparam int DIM_W   = 13;   // holds an image dimension up to 4096
	localparam int SW      = 18;   // signed working width for clamping
	localparam int ADDR_W  = 25;   // linear pixel address, up to 4096*4096
	localparam int CFG_AW  = 4;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic signed [SW-1:0] ZERO_S = '0;
	localparam logic signed [SW-1:0] ONE_S  = SW'(1);

	localparam logic [2:0] OP_PIXEL   = 3'd0;
	localparam logic [2:0] OP_HLINE   = 3'd1;
	localparam logic [2:0] OP_VLINE   = 3'd2;
	localparam logic [2:0] OP_FILL    = 3'd3;
	localparam logic [2:0] OP_OUTLINE = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;

	// job kinds carried from front to back
	localparam logic [1:0] K_RECT = 2'd0;
	localparam logic [1:0] K_READ = 2'd1;
	localparam logic [1:0] K_DONE = 2'd2;

	// register index = paddr[3:2]
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GRAY   = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] xs;
		logic [COORD_W-1:0] xe;
		logic [COORD_W-1:0] ys;
		logic [COORD_W-1:0] ye;
		logic [23:0]        color;  // {blue, green, red}
	} job_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;     // active width, already saturated
		logic [DIM_W-1:0] h;
		logic             gray;
	} cfg_t;

	// (r+g+b)/3 as a multiply by 683/2048, exact for sums up to 765
	function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = {2'b0, r} + {2'b0, g} + {2'b0, b};
		prod = {10'd0, sum} * 20'd683;
		return prod[18:11];
	endfunction

endpackage

### rtl/rld_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
interface rld_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic signed [15:0] x0;
	logic signed [15:0] y0;
	logic signed [15:0] x1;
	logic signed [15:0] y1;
	logic [7:0]         color_red;
	logic [7:0]         color_green;
	logic [7:0]         color_blue;
	logic [7:0]         thickness;

	modport source(output valid, op, x0, y0, x1, y1, color_red, color_green, color_blue,
		thickness, input ready);
	modport sink(input valid, op, x0, y0, x1, y1, color_red, color_green, color_blue,
		thickness, output ready);
endinterface

interface rld_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_red;
	logic [7:0] read_green;
	logic [7:0] read_blue;
	logic       read_valid;

	modport source(output valid, read_red, read_green, read_blue, read_valid, input ready);
	modport sink(input valid, read_red, read_green, read_blue, read_valid, output ready);
endinterface

### rtl/rld_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rld_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 65536
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                           wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                           rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

### rtl/rld_queue.sv
// Short job queue between the front (classify) and back (draw) parts.
// Depends on rld_pkg.
module rld_queue import rld_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output job_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            slot_q [DEPTH];
	logic [IW-1:0]   wr_q, rd_q;
	logic [IW:0]     cnt_q;
	logic            push, pop;

	assign push_ready = (cnt_q != (IW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### rtl/rld_front.sv
// Front part: takes command beats, clamps to the image and splits each
// command into rectangle jobs plus one closing job. Depends on rld_pkg.
module rld_front import rld_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic clr_busy,
	rld_cmd_if.sink cmd,
	output job_t job,
	output logic job_valid,
	input  logic job_ready
);
	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_CLAMP = 2'd1;
	localparam logic [1:0] F_GEN   = 2'd2;

	logic [1:0] state_q;
	logic [2:0] piece_q;

	logic [2:0]         op_q;
	logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
	logic [7:0]         r_q, g_q, b_q, th_q;

	logic signed [SW-1:0] l_q, rt_q, t_q, bt_q;
	logic                 ok_q;
	logic [23:0]          color_q;

	logic signed [SW-1:0] wm1, hm1, sx0, sy0, sx1, sy1, cl, cr, ct, cb;
	logic signed [SW-1:0] nl, nr, nt, nb, thm1;
	logic signed [SW-1:0] pl, pr, pt, pb;
	logic                 nok, pvalid, advance;
	logic [1:0]           pkind;

	function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [SW-1:0] clampv(input logic signed [SW-1:0] v,
			input logic signed [SW-1:0] hi);
		return (v < ZERO_S) ? ZERO_S : ((v > hi) ? hi : v);
	endfunction

	assign cmd.ready = (state_q == F_IDLE) && !clr_busy;

	assign wm1 = $signed({{(SW-DIM_W){1'b0}}, cfg.w}) - ONE_S;
	assign hm1 = $signed({{(SW-DIM_W){1'b0}}, cfg.h}) - ONE_S;
	assign sx0 = SW'(x0_q);
	assign sy0 = SW'(y0_q);
	assign sx1 = SW'(x1_q);
	assign sy1 = SW'(y1_q);
	assign cl  = clampv(sx0, wm1);
	assign cr  = clampv(sx1, wm1);
	assign ct  = clampv(sy0, hm1);
	assign cb  = clampv(sy1, hm1);

	// clamp stage: bounding box and draw-or-not per op
	always_comb begin
		nl  = sx0;
		nr  = sx0;
		nt  = sy0;
		nb  = sy0;
		nok = 1'b0;
		unique case (op_q)
			OP_PIXEL, OP_READ: begin
				nok = (sx0 >= ZERO_S) && (sy0 >= ZERO_S) && (sx0 <= wm1) && (sy0 <= hm1);
			end
			OP_HLINE: begin
				nl  = smax(smin(sx0, sx1), ZERO_S);
				nr  = smin(smax(sx0, sx1), wm1);
				nok = (nl <= nr) && (sy0 >= ZERO_S) && (sy0 <= hm1);
			end
			OP_VLINE: begin
				nt  = smax(smin(sy0, sy1), ZERO_S);
				nb  = smin(smax(sy0, sy1), hm1);
				nok = (nt <= nb) && (sx0 >= ZERO_S) && (sx0 <= wm1);
			end
			OP_FILL: begin
				nl  = smin(cl, cr);
				nr  = smax(cl, cr);
				nt  = smin(ct, cb);
				nb  = smax(ct, cb);
				nok = (cfg.w != '0) && (cfg.h != '0);
			end
			OP_OUTLINE: begin
				nl  = cl;
				nr  = cr;
				nt  = ct;
				nb  = cb;
				nok = (cfg.w != '0) && (cfg.h != '0) && (th_q != '0) && (cr > cl) && (cb > ct);
			end
			default: nok = 1'b0;
		endcase
	end

	// piece generation: outline gives top, bottom, left, right bands
	assign thm1 = $signed({{(SW-8){1'b0}}, th_q}) - ONE_S;

	always_comb begin
		pl     = l_q;
		pr     = rt_q;
		pt     = t_q;
		pb     = bt_q;
		pkind  = K_RECT;
		pvalid = 1'b0;
		unique case (piece_q)
			3'd0: begin
				pvalid = ok_q && (op_q <= OP_OUTLINE);
				if (op_q == OP_OUTLINE)
					pb = smin(t_q + thm1, hm1);
			end
			3'd1: begin
				pvalid = ok_q && (op_q == OP_OUTLINE);
				pt     = smax(bt_q - thm1, ZERO_S);
			end
			3'd2: begin
				pvalid = ok_q && (op_q == OP_OUTLINE);
				pr     = smin(l_q + thm1, wm1);
			end
			3'd3: begin
				pvalid = ok_q && (op_q == OP_OUTLINE);
				pl     = smax(rt_q - thm1, ZERO_S);
			end
			default: begin
				pvalid = 1'b1;
				pkind  = (ok_q && (op_q == OP_READ)) ? K_READ : K_DONE;
			end
		endcase
	end

	assign job.kind  = pkind;
	assign job.xs    = pl[COORD_W-1:0];
	assign job.xe    = pr[COORD_W-1:0];
	assign job.ys    = pt[COORD_W-1:0];
	assign job.ye    = pb[COORD_W-1:0];
	assign job.color = color_q;
	assign job_valid = (state_q == F_GEN) && pvalid;
	assign advance   = !pvalid || job_ready;

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q <= cmd.op;
			x0_q <= cmd.x0;
			y0_q <= cmd.y0;
			x1_q <= cmd.x1;
			y1_q <= cmd.y1;
			r_q  <= cmd.color_red;
			g_q  <= cmd.color_green;
			b_q  <= cmd.color_blue;
			th_q <= cmd.thickness;
		end
		if (state_q == F_CLAMP) begin
			l_q     <= nl;
			rt_q    <= nr;
			t_q     <= nt;
			bt_q    <= nb;
			ok_q    <= nok;
			color_q <= cfg.gray ? {16'd0, gray_of(r_q, g_q, b_q)} : {b_q, g_q, r_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			piece_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (cmd.valid && cmd.ready)
						state_q <= F_CLAMP;
				end
				F_CLAMP: begin
					piece_q <= '0;
					state_q <= F_GEN;
				end
				F_GEN: begin
					if (advance) begin
						if (piece_q == 3'd4)
							state_q <= F_IDLE;
						else
							piece_q <= piece_q + 1'b1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

### rtl/rld_back.sv
// Back part: clears the frame store after reset, walks rectangle jobs one
// pixel per cycle, serves reads and holds the result beat. Depends on rld_pkg, rld_ram.
module rld_back import rld_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t job,
	input  logic job_valid,
	output logic job_ready,
	output logic clr_busy,
	rld_res_if.source res
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] B_CLR   = 3'd0;
	localparam logic [2:0] B_IDLE  = 3'd1;
	localparam logic [2:0] B_SETUP = 3'd2;
	localparam logic [2:0] B_RUN   = 3'd3;
	localparam logic [2:0] B_RD    = 3'd4;
	localparam logic [2:0] B_RDCAP = 3'd5;
	localparam logic [2:0] B_FIN   = 3'd6;

	logic [2:0]         state_q;
	job_t               cur_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [ADDR_W-1:0]  addr_q, row_q, base;
	logic [AW-1:0]      clr_q;

	logic               ram_we, ram_re, out_free, load;
	logic [AW-1:0]      ram_waddr;
	logic [23:0]        ram_wdata, ram_rdata;
	logic [7:0]         ld_r, ld_g, ld_b;
	logic               ld_v;

	logic               out_valid_q;
	logic [7:0]         out_r_q, out_g_q, out_b_q;
	logic               out_v_q;

	assign clr_busy  = (state_q == B_CLR);
	assign job_ready = (state_q == B_IDLE);
	assign base      = ADDR_W'(cur_q.ys) * ADDR_W'(MAX_WIDTH);

	assign ram_we    = (state_q == B_CLR) || (state_q == B_RUN);
	assign ram_waddr = (state_q == B_CLR) ? clr_q : addr_q[AW-1:0];
	assign ram_wdata = (state_q == B_CLR) ? 24'd0 : cur_q.color;
	assign ram_re    = (state_q == B_RD);

	rld_ram #(.W(24), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || res.ready;
	assign load     = out_free && ((state_q == B_RDCAP) || (state_q == B_FIN));
	assign ld_v     = (state_q == B_RDCAP);
	assign ld_r     = ld_v ? ram_rdata[7:0] : 8'd0;
	assign ld_g     = (ld_v && !cfg.gray) ? ram_rdata[15:8] : 8'd0;
	assign ld_b     = (ld_v && !cfg.gray) ? ram_rdata[23:16] : 8'd0;

	assign res.valid      = out_valid_q;
	assign res.read_red   = out_r_q;
	assign res.read_green = out_g_q;
	assign res.read_blue  = out_b_q;
	assign res.read_valid = out_v_q;

	always_ff @(posedge clk) begin
		if (job_valid && job_ready)
			cur_q <= job;
		if (load) begin
			out_r_q <= ld_r;
			out_g_q <= ld_g;
			out_b_q <= ld_b;
			out_v_q <= ld_v;
		end
		if (state_q == B_SETUP) begin
			row_q  <= base;
			addr_q <= base + ADDR_W'(cur_q.xs);
			x_q    <= cur_q.xs;
			y_q    <= cur_q.ys;
		end else if (state_q == B_RUN) begin
			if (x_q == cur_q.xe) begin
				y_q    <= y_q + 1'b1;
				x_q    <= cur_q.xs;
				row_q  <= row_q + ADDR_W'(MAX_WIDTH);
				addr_q <= row_q + ADDR_W'(MAX_WIDTH) + ADDR_W'(cur_q.xs);
			end else begin
				x_q    <= x_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (job_valid)
						state_q <= B_SETUP;
				end
				B_SETUP: begin
					priority case (cur_q.kind)
						K_RECT:  state_q <= B_RUN;
						K_READ:  state_q <= B_RD;
						default: state_q <= B_FIN;
					endcase
				end
				B_RUN: begin
					if ((x_q == cur_q.xe) && (y_q == cur_q.ye))
						state_q <= B_IDLE;
				end
				B_RD:    state_q <= B_RDCAP;
				B_RDCAP: if (out_free) state_q <= B_IDLE;
				B_FIN:   if (out_free) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_run_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN) |-> (addr_q < ADDR_W'(DEPTH)))
		else $error("pixel address beyond frame store");
	a_run_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RUN) |-> ((x_q <= cur_q.xe) && (y_q <= cur_q.ye)))
		else $error("pixel walk left its rectangle");
	a_rdcap_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RDCAP) |-> ($past(state_q) == B_RD || $past(state_q) == B_RDCAP))
		else $error("read capture without a read");
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |=> !$rose(out_valid_q))
		else $error("result produced during clear pass");
`endif
endmodule

### rtl/rect_line_draw_engine_unit.sv
// Draw engine top level; uses rld_pkg, rld_if, rld_front, rld_queue and rld_back.
// A read's result beat follows the front's clamp and piece states, the queue and the back's
// setup, read and capture states; a draw's beat follows its last pixel write. A rectangle
// job passes a setup state, then writes its pixels in the run state. The front takes a new
// command only after its last job is queued (an outline splits into up to four jobs). Reset:
// control state clears, then a clear pass zeroes all MAX_WIDTH*MAX_HEIGHT pixels, no command taken.
module rect_line_draw_engine_unit import rld_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	rld_cmd_if.sink           cmd,
	rld_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	// configuration registers
	logic [8:0] width_q, height_q;
	logic       gray_q;
	logic       wr_en;
	cfg_t       cfg;

	// front -> queue -> back
	job_t fj, bj;
	logic fj_valid, fj_ready, bj_valid, bj_ready, clr_busy;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			gray_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				REG_GRAY:   gray_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {23'd0, width_q};
			REG_HEIGHT: prdata = {23'd0, height_q};
			REG_GRAY:   prdata = {31'd0, gray_q};
			default:    prdata = 32'd0;
		endcase
	end

	// saturate the active size to the store
	assign cfg.w    = (32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_q);
	assign cfg.h    = (32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(height_q);
	assign cfg.gray = gray_q;

	rld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clr_busy  (clr_busy),
		.cmd       (cmd),
		.job       (fj),
		.job_valid (fj_valid),
		.job_ready (fj_ready)
	);

	rld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (fj),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.pop_data   (bj),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready)
	);

	rld_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (bj),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.clr_busy  (clr_busy),
		.res       (res)
	);
endmodule

### bench/rect_line_draw_engine_unit_test.sv
// Self-checking bench for the rectangle/line draw engine: directed and random draw
// and read commands across several image settings, checked against a local frame model.
// Depends on rld_pkg, rld_if and rect_line_draw_engine_unit from the rtl folder.
module rect_line_draw_engine_unit_test;
	import rld_pkg::*;

	// op codes the block leaves unused
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int FB_W       = 256;     // frame store row pitch
	localparam int DRAIN_WAIT = 70000;   // covers a full-image fill still being written

	typedef struct {
		logic [2:0]         op;
		logic signed [15:0] x0, y0, x1, y1;
		logic [7:0]         r, g, b, th;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] r, g, b;
		logic       v;
	} pix_read_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	rld_cmd_if cmd_ch();
	rld_res_if res_ch();

	rect_line_draw_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Frame model: own copy of the store and the three registers
	// ---------------------------------------------------------------
	logic [23:0] frame [0:FB_W*256-1];
	logic [8:0]  img_w, img_h;
	logic        gray_on;
	int          errors = 0;

	function automatic int act_w();
		return (img_w > 256) ? 256 : int'(img_w);
	endfunction

	function automatic int act_h();
		return (img_h > 256) ? 256 : int'(img_h);
	endfunction

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void paint(int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int sum;
		if (x < 0 || y < 0 || x >= act_w() || y >= act_h())
			return;
		sum = int'(r) + int'(g) + int'(b);
		if (gray_on)
			frame[y*FB_W + x] = 24'(sum / 3);
		else
			frame[y*FB_W + x] = {b, g, r};
	endfunction

	function automatic void row_span(int xa, int xb, int y, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		int s, e;
		s = (xa < xb) ? xa : xb;
		e = (xa < xb) ? xb : xa;
		if (s < 0) s = 0;
		if (e > act_w() - 1) e = act_w() - 1;
		for (int x = s; x <= e; x++)
			paint(x, y, r, g, b);
	endfunction

	function automatic void col_span(int ya, int yb, int x, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		int s, e;
		s = (ya < yb) ? ya : yb;
		e = (ya < yb) ? yb : ya;
		if (s < 0) s = 0;
		if (e > act_h() - 1) e = act_h() - 1;
		for (int y = s; y <= e; y++)
			paint(x, y, r, g, b);
	endfunction

	// Applies one command to the frame model and returns the beat it should produce.
	function automatic pix_read_t draw_and_predict(draw_cmd_t c);
		pix_read_t o;
		int w, h, l, rt, t, bt, k;
		logic [23:0] p;
		o = '{8'd0, 8'd0, 8'd0, 1'b0};
		w = act_w();
		h = act_h();
		case (c.op)
			OP_PIXEL: paint(c.x0, c.y0, c.r, c.g, c.b);
			OP_HLINE: row_span(c.x0, c.x1, c.y0, c.r, c.g, c.b);
			OP_VLINE: col_span(c.y0, c.y1, c.x0, c.r, c.g, c.b);
			OP_FILL, OP_OUTLINE: begin
				if (w != 0 && h != 0) begin
					l  = clamp(c.x0, 0, w - 1);
					rt = clamp(c.x1, 0, w - 1);
					t  = clamp(c.y0, 0, h - 1);
					bt = clamp(c.y1, 0, h - 1);
					if (c.op == OP_FILL) begin
						// reversed corners are swapped after clamping
						if (rt < l) begin k = l; l = rt; rt = k; end
						if (bt < t) begin k = t; t = bt; bt = k; end
						for (int y = t; y <= bt; y++)
							for (int x = l; x <= rt; x++)
								paint(x, y, c.r, c.g, c.b);
					end else if (c.th != 0 && rt > l && bt > t) begin
						for (int i = 0; i < int'(c.th); i++) begin
							row_span(l, rt, t + i, c.r, c.g, c.b);
							row_span(l, rt, bt - i, c.r, c.g, c.b);
							col_span(t, bt, l + i, c.r, c.g, c.b);
							col_span(t, bt, rt - i, c.r, c.g, c.b);
						end
					end
				end
			end
			OP_READ: begin
				if (c.x0 >= 0 && c.y0 >= 0 && c.x0 < w && c.y0 < h) begin
					p = frame[int'(c.y0)*FB_W + int'(c.x0)];
					o.r = p[7:0];
					if (!gray_on) begin
						o.g = p[15:8];
						o.b = p[23:16];
					end
					o.v = 1'b1;
				end
			end
			default: ;   // spare codes draw nothing
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------
	// Command driver: feeds pending commands, predicts at issue time.
	// Order of issue equals order of acceptance, and registers never
	// change while commands are in flight, so predicting here is safe.
	// ---------------------------------------------------------------
	draw_cmd_t pending_cmds[$];
	pix_read_t expected_beats[$];
	int        send_gap = 0;
	bit        quiet = 1'b0;

	always @(posedge clk) begin : cmd_driver
		draw_cmd_t c;
		if (arst_n && (!cmd_ch.valid || cmd_ch.ready)) begin
			if (send_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				cmd_ch.op          <= c.op;
				cmd_ch.x0          <= c.x0;
				cmd_ch.y0          <= c.y0;
				cmd_ch.x1          <= c.x1;
				cmd_ch.y1          <= c.y1;
				cmd_ch.color_red   <= c.r;
				cmd_ch.color_green <= c.g;
				cmd_ch.color_blue  <= c.b;
				cmd_ch.thickness   <= c.th;
				cmd_ch.valid       <= 1'b1;
				expected_beats.push_back(draw_and_predict(c));
				// idle burst after this beat
				if (!quiet && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 14);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: random stalls, one long hold-off on request
	// ---------------------------------------------------------------
	int stall_left = 0;
	int hold_left  = 0;
	bit hold_req   = 1'b0;
	bit hold_done  = 1'b0;

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin : res_monitor
		pix_read_t e;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_beats.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					e = expected_beats.pop_front();
					if (res_ch.read_red !== e.r)
						report($sformatf("read_red %0h, want %0h", res_ch.read_red, e.r));
					if (res_ch.read_green !== e.g)
						report($sformatf("read_green %0h, want %0h", res_ch.read_green, e.g));
					if (res_ch.read_blue !== e.b)
						report($sformatf("read_blue %0h, want %0h", res_ch.read_blue, e.b));
					if (res_ch.read_valid !== e.v)
						report($sformatf("read_valid %0b, want %0b", res_ch.read_valid, e.v));
				end
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				// long hold-off so the block backs up and stalls its input
				hold_done <= 1'b1;
				hold_left <= 400;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				stall_left <= $urandom_range(0, 13);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic push(logic [2:0] op, int x0, int y0, int x1, int y1, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [7:0] th);
		draw_cmd_t c;
		c = '{op, 16'(x0), 16'(y0), 16'(x1), 16'(y1), r, g, b, th};
		pending_cmds.push_back(c);
	endtask

	// APB write: setup cycle, then access cycle; model follows at the write edge.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH:  img_w = val[8:0];
			REG_HEIGHT: img_h = val[8:0];
			REG_GRAY:   gray_on = val[0];
			default: ;
		endcase
	endtask

	// Idle point: everything answered, then room for trailing pixel writes.
	task automatic drain();
		while (pending_cmds.size() != 0 || expected_beats.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Random command: coordinates mostly in a small window around the image
	// so draws stay short; now and then full 16-bit values on non-rect ops.
	task automatic push_random();
		int w, h, lim_x, lim_y, bx, by, sel, x0, y0, x1, y1;
		logic [2:0] op;
		logic [7:0] th;
		w = act_w();
		h = act_h();
		sel = $urandom_range(0, 99);
		op = (sel < 30) ? OP_READ : (sel < 45) ? OP_PIXEL : (sel < 55) ? OP_HLINE :
			(sel < 65) ? OP_VLINE : (sel < 80) ? OP_FILL : (sel < 95) ? OP_OUTLINE :
			(sel[0] ? OP_SPARE6 : OP_SPARE7);
		lim_x = (w > 32) ? 24 : w;
		lim_y = (h > 32) ? 24 : h;
		bx = (w > 32) ? $urandom_range(0, w - 1) : 0;
		by = (h > 32) ? $urandom_range(0, h - 1) : 0;
		x0 = bx + $urandom_range(0, lim_x + 5) - 3;
		x1 = bx + $urandom_range(0, lim_x + 5) - 3;
		y0 = by + $urandom_range(0, lim_y + 5) - 3;
		y1 = by + $urandom_range(0, lim_y + 5) - 3;
		if (op != OP_FILL && op != OP_OUTLINE && $urandom_range(0, 5) == 0) begin
			x0 = $urandom; y0 = $urandom; x1 = $urandom; y1 = $urandom;
		end
		th = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		push(op, x0, y0, x1, y1, 8'($urandom), 8'($urandom), 8'($urandom), th);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	int phase_w [6] = '{20, 1, 256, 0, 511, 9};
	int phase_h [6] = '{16, 1, 256, 5, 3, 7};
	bit phase_g [6] = '{0, 1, 1, 0, 1, 0};

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cmd_ch.valid = 1'b0; cmd_ch.op = OP_PIXEL;
		cmd_ch.x0 = '0; cmd_ch.y0 = '0; cmd_ch.x1 = '0; cmd_ch.y1 = '0;
		cmd_ch.color_red = '0; cmd_ch.color_green = '0; cmd_ch.color_blue = '0;
		cmd_ch.thickness = '0;
		res_ch.ready = 1'b0;
		img_w = 9'd256; img_h = 9'd256; gray_on = 1'b0;
		for (int i = 0; i < FB_W*256; i++)
			frame[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings (256x256, colour)
		push(OP_PIXEL, 0, 0, 0, 0, 8'hff, 8'h00, 8'h80, 8'd0);
		push(OP_PIXEL, 255, 255, 0, 0, 8'h12, 8'h34, 8'h56, 8'd0);
		push(OP_PIXEL, -1, 5, 0, 0, 8'hff, 8'hff, 8'hff, 8'd0);      // off left edge
		push(OP_PIXEL, 256, 0, 0, 0, 8'hff, 8'hff, 8'hff, 8'd0);     // off right edge
		push(OP_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_READ, 255, 255, 0, 0, 8'hff, 8'hff, 8'hff, 8'hff);
		push(OP_READ, -32768, 32767, 32767, -32768, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_HLINE, 10, 2, 3, 0, 8'haa, 8'h55, 8'h0f, 8'd0);      // reversed ends
		push(OP_READ, 3, 2, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_VLINE, 4, 9, 0, -5, 8'h01, 8'h80, 8'hfe, 8'd0);      // reversed, clipped
		push(OP_READ, 4, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_FILL, 20, 20, 17, 15, 8'h77, 8'h66, 8'h55, 8'd0);    // swapped corners
		push(OP_READ, 18, 17, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_OUTLINE, 30, 30, 30, 40, 8'hff, 8'hff, 8'hff, 8'd2); // zero width
		push(OP_OUTLINE, 30, 30, 35, 40, 8'hff, 8'hff, 8'hff, 8'd0); // zero thickness
		push(OP_OUTLINE, 40, 40, 50, 48, 8'h11, 8'h22, 8'h33, 8'd2);
		push(OP_READ, 41, 41, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_READ, 42, 42, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);      // interior untouched
		push(OP_SPARE6, 1, 1, 5, 5, 8'hff, 8'hff, 8'hff, 8'hff);
		push(OP_SPARE7, 1, 1, 5, 5, 8'hff, 8'hff, 8'hff, 8'hff);
		push(OP_OUTLINE, 60, 60, 63, 62, 8'h9c, 8'h3e, 8'h71, 8'hff); // thickness past size
		push(OP_FILL, -32768, -32768, 32767, 32767, 8'h01, 8'h02, 8'h03, 8'd0); // whole image
		push(OP_READ, 128, 200, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		push(OP_HLINE, -32768, 7, 32767, 0, 8'hc3, 8'h3c, 8'h5a, 8'd0);
		push(OP_READ, 200, 7, 0, 0, 8'h00, 8'h00, 8'h00, 8'd0);
		drain();

		// random part over several register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_WIDTH, 32'(phase_w[ph]));
			write_reg(REG_HEIGHT, 32'(phase_h[ph]));
			write_reg(REG_GRAY, 32'(phase_g[ph]));
			if (ph == 5)
				quiet = 1'b1;
			for (int i = 0; i < 17; i++)
				push_random();
			if (ph == 2) begin
				@(posedge clk);
				hold_req <= 1'b1;
			end
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run limit: several times the slowest correct run
	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

endmodule
